/* hdl/imu_vi_pkg.sv */
// ----------------------------------------------------------------------------
// imu_vi_pkg
// Shared types and constants of the IMU velocity integrator: word formats,
// register map, multiply-accumulate control and fixed-point constants.
// ----------------------------------------------------------------------------
package imu_vi_pkg;

  // Input word: timestamp, raw accelerometer axes and orientation quaternion
  typedef struct packed {
    logic        [31:0] time_ms;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic               updated;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic signed [15:0] lin_acc_x;
    logic signed [15:0] lin_acc_y;
    logic signed [15:0] lin_acc_z;
  } out_word_t;

  // Register map (index = byte address / 4)
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_ALPHA    = 2'd1;
  localparam logic [1:0] REG_THRESH   = 2'd2;

  localparam logic [9:0]  INTERVAL_RST = 10'd10;
  localparam logic [16:0] ALPHA_RST    = 17'd32768;
  localparam logic [14:0] THRESH_RST   = 15'd128;

  typedef struct packed {
    logic [9:0]  interval;
    logic [16:0] alpha;
    logic [14:0] thresh;
  } cfg_t;

  // Shared multiply-accumulate unit
  localparam int unsigned MAC_A_W = 36;
  localparam int unsigned MAC_B_W = 25;
  localparam int unsigned ACC_W   = 48;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_mode_e;

  typedef struct packed {
    logic                      en;
    mac_mode_e                 mode;
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_B_W-1:0] b;
  } mac_ctrl_t;

  // Fixed-point constants
  localparam logic signed [MAC_B_W-1:0] RAW_TO_Q28 = 25'sd16384;   // 1 g in Q.28 / raw LSB
  localparam logic signed [MAC_B_W-1:0] G_SCALE    = 25'sd981;     // 9.81 * 100
  // ceil(2^29 / 100): exact floor(x / 100) for x below 2^22
  localparam logic signed [MAC_B_W-1:0] RECIP_100  = 25'sd5368710;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [26:0] ROUND_X    = 27'd50;       // half of 100 after the 2^20 shift
  localparam logic [26:0] SAT_X      = 27'd3276800;  // 100 * 32768
  localparam logic [16:0] ALPHA_ONE  = 17'd65536;
  localparam logic [15:0] DT_CAP     = 16'hFFFF;

endpackage

/* hdl/imu_vi_cfg.sv */
// ----------------------------------------------------------------------------
// imu_vi_cfg
// APB-style register block: sample interval, smoothing weight, noise deadband.
// ----------------------------------------------------------------------------
module imu_vi_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output imu_vi_pkg::cfg_t   cfg_o
);
  import imu_vi_pkg::*;

  logic [1:0] idx;
  logic       wr_en;
  cfg_t       cfg_q;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval <= INTERVAL_RST;
      cfg_q.alpha    <= ALPHA_RST;
      cfg_q.thresh   <= THRESH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_INTERVAL: cfg_q.interval <= pwdata[9:0];
        REG_ALPHA:    cfg_q.alpha    <= pwdata[16:0];
        REG_THRESH:   cfg_q.thresh   <= pwdata[14:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INTERVAL: prdata = {22'd0, cfg_q.interval};
      REG_ALPHA:    prdata = {15'd0, cfg_q.alpha};
      REG_THRESH:   prdata = {17'd0, cfg_q.thresh};
      default:      prdata = '0;
    endcase
  end

endmodule

/* hdl/imu_vi_mac.sv */
// ----------------------------------------------------------------------------
// imu_vi_mac
// Shared signed multiply-accumulate unit: while enabled, load, add or
// subtract one product per cycle into a 48-bit accumulator.
// ----------------------------------------------------------------------------
module imu_vi_mac (
  input  logic                                   clk_i,
  input  imu_vi_pkg::mac_ctrl_t                  ctrl_i,
  output logic signed [imu_vi_pkg::ACC_W-1:0]    acc_o
);
  import imu_vi_pkg::*;

  logic signed [MAC_A_W+MAC_B_W-1:0] prod;
  logic signed [ACC_W-1:0]           prod_t;
  logic signed [ACC_W-1:0]           acc_d;
  logic signed [ACC_W-1:0]           acc_q;

  assign prod   = $signed(ctrl_i.a) * $signed(ctrl_i.b);
  assign prod_t = prod[ACC_W-1:0];
  assign acc_o  = acc_q;

  always_comb begin
    case (ctrl_i.mode)
      MAC_LOAD: acc_d = prod_t;
      MAC_ADD:  acc_d = acc_q + prod_t;
      MAC_SUB:  acc_d = acc_q - prod_t;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

endmodule

/* hdl/imu_vi_ctrl.sv */
// ----------------------------------------------------------------------------
// imu_vi_ctrl
// Sequencer and state of the integrator: steps the shared MAC through
// gravity removal, scaling, smoothing and velocity update; holds the result.
// ----------------------------------------------------------------------------
module imu_vi_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  imu_vi_pkg::cfg_t                    cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  imu_vi_pkg::in_word_t                in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output imu_vi_pkg::out_word_t               out_word_o,
  output imu_vi_pkg::mac_ctrl_t               mac_o,
  input  logic signed [imu_vi_pkg::ACC_W-1:0] acc_i
);
  import imu_vi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_GRAV  = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_RND   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_SM0   = 4'd7;
  localparam logic [3:0] S_SM1   = 4'd8;
  localparam logic [3:0] S_SMR   = 4'd9;
  localparam logic [3:0] S_VMUL  = 4'd10;
  localparam logic [3:0] S_VADD  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic [1:0] AXIS_Z  = 2'd2;

  logic [3:0]  state_q, state_d;
  logic [1:0]  axis_q;
  logic [2:0]  op_q;
  in_word_t    in_q;
  logic [15:0] dt_q;
  logic [31:0] last_q;
  logic        upd_q;
  logic        neg_q, sat_q;
  logic [21:0] x_q;
  logic signed [15:0] lin_q    [3];
  logic signed [15:0] smooth_q [3];
  logic signed [47:0] vel_q    [3];
  out_word_t   out_q;
  logic        out_valid_q;

  logic        accept;
  logic        load_out;
  logic [31:0] dt_full;
  logic        early;
  logic        grav_last;
  logic signed [15:0] raw_sel;
  logic [16:0] alpha_eff;

  // rounding of the scaled acceleration
  logic        p_neg;
  logic [47:0] p_mag;
  logic [26:0] x_full;

  // quotient, clamp and deadband
  logic [14:0] quo;
  logic signed [15:0] a_val;
  logic [15:0] a_mag;
  logic        dead;

  // smoothing round
  logic        t_neg;
  logic [47:0] t_mag;
  logic [16:0] qs;
  logic signed [15:0] s_val;

  // velocity update
  logic        clear_v;
  logic signed [47:0] v_base;
  logic signed [48:0] v_sum;
  logic signed [47:0] v_sat;

  out_word_t   out_d;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign dt_full = in_q.time_ms - last_q;
  assign early   = dt_full < {22'd0, cfg_i.interval};

  assign alpha_eff = (cfg_i.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha;

  always_comb begin
    case (axis_q)
      2'd0:    raw_sel = in_q.accel_x_raw;
      2'd1:    raw_sel = in_q.accel_y_raw;
      default: raw_sel = in_q.accel_z_raw;
    endcase
  end

  // MAC operand selection
  always_comb begin
    mac_o      = '{en: 1'b0, mode: MAC_LOAD, a: '0, b: '0};
    grav_last  = 1'b0;
    case (state_q)
      S_GRAV: begin
        mac_o.en = 1'b1;
        if (op_q == 3'd0) begin
          mac_o.mode = MAC_LOAD;
          mac_o.a    = MAC_A_W'(raw_sel);
          mac_o.b    = RAW_TO_Q28;
        end else begin
          case (axis_q)
            2'd0: begin
              // d = raw - 2(qx*qz - qw*qy)
              grav_last = (op_q == 3'd2);
              if (op_q == 3'd1) begin
                mac_o.mode = MAC_SUB;
                mac_o.a    = MAC_A_W'(in_q.quat_x) <<< 1;
                mac_o.b    = MAC_B_W'(in_q.quat_z);
              end else begin
                mac_o.mode = MAC_ADD;
                mac_o.a    = MAC_A_W'(in_q.quat_w) <<< 1;
                mac_o.b    = MAC_B_W'(in_q.quat_y);
              end
            end
            2'd1: begin
              // d = raw - 2(qw*qx + qy*qz)
              grav_last  = (op_q == 3'd2);
              mac_o.mode = MAC_SUB;
              if (op_q == 3'd1) begin
                mac_o.a = MAC_A_W'(in_q.quat_w) <<< 1;
                mac_o.b = MAC_B_W'(in_q.quat_x);
              end else begin
                mac_o.a = MAC_A_W'(in_q.quat_y) <<< 1;
                mac_o.b = MAC_B_W'(in_q.quat_z);
              end
            end
            default: begin
              // d = raw - (qw^2 - qx^2 - qy^2 + qz^2)
              grav_last = (op_q == 3'd4);
              case (op_q)
                3'd1: begin
                  mac_o.mode = MAC_SUB;
                  mac_o.a    = MAC_A_W'(in_q.quat_w);
                  mac_o.b    = MAC_B_W'(in_q.quat_w);
                end
                3'd2: begin
                  mac_o.mode = MAC_ADD;
                  mac_o.a    = MAC_A_W'(in_q.quat_x);
                  mac_o.b    = MAC_B_W'(in_q.quat_x);
                end
                3'd3: begin
                  mac_o.mode = MAC_ADD;
                  mac_o.a    = MAC_A_W'(in_q.quat_y);
                  mac_o.b    = MAC_B_W'(in_q.quat_y);
                end
                default: begin
                  mac_o.mode = MAC_SUB;
                  mac_o.a    = MAC_A_W'(in_q.quat_z);
                  mac_o.b    = MAC_B_W'(in_q.quat_z);
                end
              endcase
            end
          endcase
        end
      end
      S_SCALE: begin
        mac_o.en   = 1'b1;
        mac_o.mode = MAC_LOAD;
        mac_o.a    = acc_i[MAC_A_W-1:0];
        mac_o.b    = G_SCALE;
      end
      S_DIV: begin
        mac_o.en   = 1'b1;
        mac_o.mode = MAC_LOAD;
        mac_o.a    = MAC_A_W'(x_q);
        mac_o.b    = RECIP_100;
      end
      S_SM0: begin
        mac_o.en   = 1'b1;
        mac_o.mode = MAC_LOAD;
        mac_o.a    = MAC_A_W'(alpha_eff);
        mac_o.b    = MAC_B_W'(lin_q[axis_q]);
      end
      S_SM1: begin
        mac_o.en   = 1'b1;
        mac_o.mode = MAC_ADD;
        mac_o.a    = MAC_A_W'(ALPHA_ONE - alpha_eff);
        mac_o.b    = MAC_B_W'(smooth_q[axis_q]);
      end
      S_VMUL: begin
        mac_o.en   = 1'b1;
        mac_o.mode = MAC_LOAD;
        mac_o.a    = MAC_A_W'(smooth_q[axis_q]);
        mac_o.b    = MAC_B_W'(dt_q);
      end
      default: ;
    endcase
  end

  // |d*981| / 2^20 plus 50, so the divide by 100 rounds half up; saturate flag for results beyond 16 bits
  always_comb begin
    p_neg  = acc_i[47];
    p_mag  = p_neg ? 48'(-acc_i) : 48'(acc_i);
    x_full = p_mag[46:20] + ROUND_X;
  end

  // Quotient by 100, clamp and deadband
  always_comb begin
    quo = acc_i[RECIP_SHIFT+14:RECIP_SHIFT];
    if (sat_q) begin
      a_val = neg_q ? 16'sh8000 : 16'sh7FFF;
      a_mag = neg_q ? 16'h8000 : 16'h7FFF;
    end else begin
      a_val = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      a_mag = {1'b0, quo};
    end
    dead = a_mag < {1'b0, cfg_i.thresh};
  end

  // Smoothing: round t / 65536 to nearest, ties away from zero
  always_comb begin
    t_neg = acc_i[47];
    t_mag = t_neg ? 48'(-acc_i) : 48'(acc_i);
    qs    = 17'((t_mag[32:0] + 33'd32768) >> 16);
    if (t_neg) begin
      s_val = 16'(-$signed({1'b0, qs}));
    end else if (qs > 17'd32767) begin
      s_val = 16'sh7FFF;
    end else begin
      s_val = $signed(qs[15:0]);
    end
  end

  // Velocity: add s*dt to the (possibly cleared) velocity, saturate to 48 bits
  always_comb begin
    clear_v = (lin_q[0] == 16'sd0) && (lin_q[1] == 16'sd0);
    v_base  = clear_v ? 48'sd0 : vel_q[axis_q];
    v_sum   = 49'(v_base) + 49'(acc_i);
    if (v_sum[48] != v_sum[47]) begin
      v_sat = v_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      v_sat = v_sum[47:0];
    end
  end

  always_comb begin
    out_d.updated   = upd_q;
    out_d.vel_x     = vel_q[0];
    out_d.vel_y     = vel_q[1];
    out_d.vel_z     = vel_q[2];
    out_d.lin_acc_x = smooth_q[0];
    out_d.lin_acc_y = smooth_q[1];
    out_d.lin_acc_z = smooth_q[2];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CHECK;
      S_CHECK: state_d = early ? S_DONE : S_GRAV;
      S_GRAV:  if (grav_last) state_d = S_SCALE;
      S_SCALE: state_d = S_RND;
      S_RND:   state_d = S_DIV;
      S_DIV:   state_d = S_FIN;
      S_FIN:   state_d = (axis_q == AXIS_Z) ? S_SM0 : S_GRAV;
      S_SM0:   state_d = S_SM1;
      S_SM1:   state_d = S_SMR;
      S_SMR:   state_d = S_VMUL;
      S_VMUL:  state_d = S_VADD;
      S_VADD:  state_d = (axis_q == AXIS_Z) ? S_DONE : S_SM0;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 2'd0;
      op_q        <= 3'd0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        vel_q[i]    <= '0;
        smooth_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CHECK: begin
          upd_q  <= !early;
          axis_q <= 2'd0;
          op_q   <= 3'd0;
          if (!early) last_q <= in_q.time_ms;
        end
        S_GRAV: op_q <= grav_last ? 3'd0 : op_q + 3'd1;
        S_FIN: axis_q <= (axis_q == AXIS_Z) ? 2'd0 : axis_q + 2'd1;
        S_SMR: smooth_q[axis_q] <= s_val;
        S_VADD: begin
          vel_q[axis_q] <= v_sat;
          axis_q        <= (axis_q == AXIS_Z) ? 2'd0 : axis_q + 2'd1;
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_word_i;
    if (state_q == S_CHECK) dt_q <= (|dt_full[31:16]) ? DT_CAP : dt_full[15:0];
    if (state_q == S_RND) begin
      neg_q <= p_neg;
      sat_q <= x_full >= SAT_X;
      x_q   <= x_full[21:0];
    end
    if (state_q == S_FIN) lin_q[axis_q] <= dead ? 16'sd0 : a_val;
    if (load_out) out_q <= out_d;
  end

  // Unsaturated quotient must fit 15 bits after the reciprocal multiply
  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !sat_q) |-> (acc_i[47:44] == 4'd0))
    else $error("quotient by 100 overflowed 15 bits");

  // An early word leaves the timestamp alone and goes straight to the result
  a_early_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && early) |=> (state_q == S_DONE && $stable(last_q) && !upd_q))
    else $error("early word advanced the state");

  // Axis counter stays on the three axes
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3)
    else $error("axis counter out of range");

  // A finished result is not dropped while the output register still holds one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("result left the sequencer while output was stalled");

endmodule

/* hdl/imu_velocity_integrator.sv */
// ----------------------------------------------------------------------------
// imu_velocity_integrator
// Gravity-compensated accelerometer velocity integrator with APB-style
// configuration and valid/stall word channels.
// ----------------------------------------------------------------------------
// Each input word takes a millisecond timestamp, raw accelerometer axes
// (16384 LSB per g) and an orientation quaternion in Q1.14, and gives exactly
// one result word. A word that arrives less than sample_interval_ms after the
// last taken sample returns updated = 0 with the current velocities and
// smoothed accelerations; that word goes from S_CHECK straight to S_DONE,
// and the next word can be taken once its result is in the output register.
// Any other word removes gravity, scales to Q8.8 m/s^2, applies the deadband,
// clears the velocities when X and Y both read zero, smooths each axis and
// integrates into saturating 48-bit velocities in 1/256 mm/s. Every product
// goes through a single 36 x 25 bit multiply-accumulate unit, one product
// per cycle while it is enabled: 8 products for gravity removal plus 3 per
// axis for scaling and the divide by 100, and 3 per axis for smoothing and
// integration. The input is stalled while a word is in work; a finished
// result sits in an output register, so the next word is taken while the
// previous result waits on out_stall_i. Registers sit at byte addresses 0
// (sample_interval_ms), 4 (smoothing_alpha) and 8 (noise_threshold); write
// them only while the block is idle.
// ----------------------------------------------------------------------------
module imu_velocity_integrator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input word channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  imu_vi_pkg::in_word_t    in_word_i,
  // result word channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output imu_vi_pkg::out_word_t   out_word_o,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import imu_vi_pkg::*;

  cfg_t                    cfg;
  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] mac_acc;

  // Configuration registers
  imu_vi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Shared multiply-accumulate unit; every product of the algorithm goes here
  imu_vi_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .acc_o  (mac_acc)
  );

  // Sequencer, model state and output register
  imu_vi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .mac_o       (mac_ctrl),
    .acc_i       (mac_acc)
  );

endmodule
